@@ design/i2cbl_pkg.sv @@
// i2cbl_pkg: shared types and constants for the i2c bit-level master
// used by i2cbl_front, i2cbl_engine, i2c_bit_level_master and i2cbl_checker
`timescale 1ns / 1ps

package i2cbl_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int PHASE_W       = $clog2(3 * BITS_PER_BYTE);

    localparam logic [PHASE_W-1:0] WR_LAST_PH = PHASE_W'(3 * BITS_PER_BYTE - 1);
    localparam logic [PHASE_W-1:0] RD_LAST_PH = PHASE_W'(2 * BITS_PER_BYTE);
    localparam logic [1:0]         SUB_LAST   = 2'd2;

    // input kind codes
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;
    localparam logic [2:0] KIND_SACK  = 3'd5;
    localparam logic [2:0] KIND_RACK  = 3'd6;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_SACK  = 3'd5,
        CMD_RACK  = 3'd6
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] write_data;
        logic       ack_level;
        logic       sda_sample;
    } in_word_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_seen;
    } out_word_t;

    // classified word handed from front to engine
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] write_data;
        logic       ack_level;
        logic       sda_sample;
    } entry_t;

endpackage

@@ design/i2cbl_front.sv @@
// i2cbl_front: accepts input words, decodes the command kind and queues them
// depends on i2cbl_pkg
`timescale 1ns / 1ps

module i2cbl_front #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  i2cbl_pkg::in_word_t cmd_word,
    output logic               q_valid,
    input  logic               q_ready,
    output i2cbl_pkg::entry_t  q_entry
);
    import i2cbl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    entry_t           decoded;
    logic             push;
    logic             pop;

    always_comb
    begin
        decoded.write_data = cmd_word.write_data;
        decoded.ack_level  = cmd_word.ack_level;
        decoded.sda_sample = cmd_word.sda_sample;
        unique case (cmd_word.kind)
            KIND_START: decoded.cmd = CMD_START;
            KIND_STOP:  decoded.cmd = CMD_STOP;
            KIND_WRITE: decoded.cmd = CMD_WRITE;
            KIND_READ:  decoded.cmd = CMD_READ;
            KIND_SACK:  decoded.cmd = CMD_SACK;
            KIND_RACK:  decoded.cmd = CMD_RACK;
            default:    decoded.cmd = CMD_NONE;
        endcase
    end

    assign cmd_ready = (count_reg != CNT_FULL);
    assign q_valid   = (count_reg != '0);
    assign q_entry   = mem_reg[rptr_reg];
    assign push      = cmd_valid && cmd_ready;
    assign pop       = q_valid && q_ready;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= decoded;
        end
    end

endmodule

@@ design/i2cbl_engine.sv @@
// i2cbl_engine: pin sequencer, at most one scl or sda write per word, with result register
// depends on i2cbl_pkg
`timescale 1ns / 1ps

module i2cbl_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  i2cbl_pkg::entry_t    q_entry,
    output logic                 res_valid,
    input  logic                 res_ready,
    output i2cbl_pkg::out_word_t res_word
);
    import i2cbl_pkg::*;

    cmd_t               active_reg, active_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [1:0]         sub_reg, sub_next;
    logic [7:0]         shift_reg, shift_next;
    logic               held_ack_reg, held_ack_next;
    logic               last_ack_reg, last_ack_next;
    logic [7:0]         read_res_reg, read_res_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic               res_valid_reg, res_valid_next;
    out_word_t          res_word_reg, res_word_next;

    logic               take;
    logic               launch;
    cmd_t               cur_cmd;
    logic [PHASE_W-1:0] cur_ph;
    logic [1:0]         cur_sub;
    logic               busy;
    logic               fin;

    assign q_ready   = !res_valid_reg || res_ready;
    assign take      = q_valid && q_ready;
    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    always_comb
    begin
        launch  = (active_reg == CMD_NONE) && (q_entry.cmd != CMD_NONE);
        cur_cmd = launch ? q_entry.cmd : active_reg;
        cur_ph  = launch ? '0 : phase_reg;
        cur_sub = launch ? '0 : sub_reg;
        busy    = 1'b0;
        fin     = 1'b0;

        active_next    = active_reg;
        phase_next     = phase_reg;
        sub_next       = sub_reg;
        shift_next     = shift_reg;
        held_ack_next  = held_ack_reg;
        last_ack_next  = last_ack_reg;
        read_res_next  = read_res_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_word_next  = res_word_reg;

        if (take)
        begin
            if (launch && q_entry.cmd == CMD_WRITE)
            begin
                shift_next = q_entry.write_data;
            end
            else if (launch && q_entry.cmd == CMD_READ)
            begin
                shift_next = '0;
            end
            if (launch && q_entry.cmd == CMD_SACK)
            begin
                held_ack_next = q_entry.ack_level;
            end

            busy = (cur_cmd != CMD_NONE);
            unique case (cur_cmd)
                CMD_START:
                begin
                    unique case (cur_ph)
                        PHASE_W'(0): sda_next = 1'b1;
                        PHASE_W'(1): scl_next = 1'b1;
                        PHASE_W'(2): sda_next = 1'b0;
                        default:
                        begin
                            scl_next = 1'b0;
                            fin      = 1'b1;
                        end
                    endcase
                end
                CMD_STOP:
                begin
                    unique case (cur_ph)
                        PHASE_W'(0): sda_next = 1'b0;
                        PHASE_W'(1): scl_next = 1'b1;
                        default:
                        begin
                            sda_next = 1'b1;
                            fin      = 1'b1;
                        end
                    endcase
                end
                CMD_WRITE:
                begin
                    unique case (cur_sub)
                        2'd0: sda_next = shift_next[7];
                        2'd1: scl_next = 1'b1;
                        default:
                        begin
                            scl_next   = 1'b0;
                            shift_next = {shift_next[6:0], 1'b0};
                            fin        = (cur_ph == WR_LAST_PH);
                        end
                    endcase
                end
                CMD_READ:
                begin
                    if (cur_ph == '0)
                    begin
                        sda_next = 1'b1;
                    end
                    else if (cur_ph[0])
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        shift_next = {shift_next[6:0], q_entry.sda_sample};
                        scl_next   = 1'b0;
                        if (cur_ph == RD_LAST_PH)
                        begin
                            read_res_next = shift_next;
                            fin           = 1'b1;
                        end
                    end
                end
                CMD_SACK:
                begin
                    unique case (cur_ph)
                        PHASE_W'(0): sda_next = held_ack_next;
                        PHASE_W'(1): scl_next = 1'b1;
                        default:
                        begin
                            scl_next = 1'b0;
                            fin      = 1'b1;
                        end
                    endcase
                end
                CMD_RACK:
                begin
                    unique case (cur_ph)
                        PHASE_W'(0): sda_next = 1'b1;
                        PHASE_W'(1): scl_next = 1'b1;
                        PHASE_W'(2): last_ack_next = q_entry.sda_sample;
                        default:
                        begin
                            scl_next = 1'b0;
                            fin      = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase

            if (busy)
            begin
                if (fin)
                begin
                    active_next = CMD_NONE;
                    phase_next  = '0;
                    sub_next    = '0;
                end
                else
                begin
                    active_next = cur_cmd;
                    phase_next  = cur_ph + 1'b1;
                    sub_next    = (cur_sub == SUB_LAST) ? '0 : cur_sub + 1'b1;
                end
            end

            res_valid_next          = 1'b1;
            res_word_next.scl_level = scl_next;
            res_word_next.sda_level = sda_next;
            res_word_next.busy_res  = busy;
            res_word_next.done_res  = fin;
            res_word_next.read_byte = read_res_next;
            res_word_next.ack_seen  = last_ack_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= CMD_NONE;
            phase_reg     <= '0;
            sub_reg       <= '0;
            shift_reg     <= '0;
            held_ack_reg  <= 1'b0;
            last_ack_reg  <= 1'b1;
            read_res_reg  <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            phase_reg     <= phase_next;
            sub_reg       <= sub_next;
            shift_reg     <= shift_next;
            held_ack_reg  <= held_ack_next;
            last_ack_reg  <= last_ack_next;
            read_res_reg  <= read_res_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_word_reg <= res_word_next;
    end

endmodule

@@ design/i2c_bit_level_master.sv @@
// i2c_bit_level_master: top level, front queue feeding the pin sequencer
// depends on i2cbl_pkg, i2cbl_front, i2cbl_engine
//
// usage
//   cmd channel: one word per bus interval, with the sampled sda level and an
//   optional command (start, stop, write byte, read byte, send ack, read ack)
//   that is taken only when no command is running; otherwise it is ignored
//   res channel: one word per cmd word, in order, with the scl and sda pin
//   levels for that interval (1 = released), busy, done, last read byte and
//   last ack sample
//   order: an accepted word is written into the front queue, the sequencer
//   takes it from there when its result register is free and loads that
//   register, which offers the result until res_ready takes it
//   throughput: one word per cycle while res_ready stays high; the sequencer
//   advances one pin phase per word
//   reset: pins released, no command running, ack_seen 1, read_byte 0,
//   queue empty
//   stall: a held result stops the sequencer, the front queue of QUEUE_DEPTH
//   words keeps taking words until full, then cmd_ready drops
`timescale 1ns / 1ps

module i2c_bit_level_master #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  i2cbl_pkg::in_word_t  cmd_word,
    output logic                 res_valid,
    input  logic                 res_ready,
    output i2cbl_pkg::out_word_t res_word
);
    import i2cbl_pkg::*;

    logic   q_valid;
    logic   q_ready;
    entry_t q_entry;

    i2cbl_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_word  (cmd_word),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_entry   (q_entry)
    );

    i2cbl_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_entry   (q_entry),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

endmodule

@@ design/i2cbl_checker.sv @@
// i2cbl_checker: port-level assertions for i2c_bit_level_master, bound to the top
// depends on i2cbl_pkg and i2c_bit_level_master
`timescale 1ns / 1ps

module i2cbl_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cmd_valid,
    input logic                 cmd_ready,
    input i2cbl_pkg::in_word_t  cmd_word,
    input logic                 res_valid,
    input logic                 res_ready,
    input i2cbl_pkg::out_word_t res_word
);
    import i2cbl_pkg::*;

    // held result stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_word))
        else $error("result changed while stalled");

    // completion only inside a running command
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.done_res |-> res_word.busy_res)
        else $error("done without busy");

    // every command ends with scl low, except stop which ends with both released
    a_done_pins: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.done_res |-> !res_word.scl_level || res_word.sda_level)
        else $error("bad pin levels at command end");

    // idle result never reports done
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_word.busy_res |-> !res_word.done_res)
        else $error("idle result with done set");

endmodule

bind i2c_bit_level_master i2cbl_checker u_checker (.*);

@@ tb/tb_i2c_bit_level_master.sv @@
// tb_i2c_bit_level_master: self-checking bench for the i2c bit-level master, one word per
// bus interval in, one pin/status word out; a built-in bus model predicts every result
// depends on i2cbl_pkg and i2c_bit_level_master
`timescale 1ns / 1ps

module tb_i2c_bit_level_master;

    import i2cbl_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_ready;
    in_word_t  cmd_word;
    logic      res_valid;
    logic      res_ready;
    out_word_t res_word;

    i2c_bit_level_master uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

    // bus model state
    logic       bus_scl;
    logic       bus_sda;
    cmd_t       run_cmd;
    logic [4:0] run_phase;
    logic [7:0] shift_reg;
    logic       held_ack;
    logic       ack_latch;
    logic [7:0] byte_latch;

    out_word_t  pin_results_q[$];
    int         mismatches;
    int         words_sent;
    bit         no_gaps;
    int         stall_left;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic in_word_t make_word(logic [2:0] kind, logic [7:0] data, logic ack,
                                           logic sample);
        in_word_t w;
        w.kind       = kind;
        w.write_data = data;
        w.ack_level  = ack;
        w.sda_sample = sample;
        return w;
    endfunction

    function automatic void reset_bus();
        bus_scl    = 1'b1;
        bus_sda    = 1'b1;
        run_cmd    = CMD_NONE;
        run_phase  = '0;
        shift_reg  = '0;
        held_ack   = 1'b0;
        ack_latch  = 1'b1;
        byte_latch = '0;
    endfunction

    // one bus interval of the pin sequencer
    function automatic out_word_t step_bus(in_word_t w);
        out_word_t  r;
        logic       busy;
        logic       fin;
        logic [4:0] ph;
        busy = 1'b0;
        fin  = 1'b0;
        if (run_cmd == CMD_NONE && w.kind >= KIND_START && w.kind <= KIND_RACK)
        begin
            run_cmd   = cmd_t'(w.kind);
            run_phase = '0;
            case (w.kind)
                KIND_WRITE: shift_reg = w.write_data;
                KIND_READ:  shift_reg = '0;
                KIND_SACK:  held_ack  = w.ack_level;
                default:    ;
            endcase
        end
        if (run_cmd != CMD_NONE)
        begin
            busy = 1'b1;
            ph   = run_phase;
            case (run_cmd)
                CMD_START:
                begin
                    if (ph == 0) bus_sda = 1'b1;
                    else if (ph == 1) bus_scl = 1'b1;
                    else if (ph == 2) bus_sda = 1'b0;
                    else
                    begin
                        bus_scl = 1'b0;
                        fin     = 1'b1;
                    end
                end
                CMD_STOP:
                begin
                    if (ph == 0) bus_sda = 1'b0;
                    else if (ph == 1) bus_scl = 1'b1;
                    else
                    begin
                        bus_sda = 1'b1;
                        fin     = 1'b1;
                    end
                end
                CMD_WRITE:
                begin
                    if (ph % 3 == 0) bus_sda = shift_reg[7];
                    else if (ph % 3 == 1) bus_scl = 1'b1;
                    else
                    begin
                        bus_scl   = 1'b0;
                        shift_reg = shift_reg << 1;
                        if (ph + 1 >= 3 * BITS_PER_BYTE) fin = 1'b1;
                    end
                end
                CMD_READ:
                begin
                    if (ph == 0) bus_sda = 1'b1;
                    else if (ph % 2 == 1) bus_scl = 1'b1;
                    else
                    begin
                        shift_reg = {shift_reg[6:0], w.sda_sample};
                        bus_scl   = 1'b0;
                        if (ph >= 2 * BITS_PER_BYTE)
                        begin
                            byte_latch = shift_reg;
                            fin        = 1'b1;
                        end
                    end
                end
                CMD_SACK:
                begin
                    if (ph == 0) bus_sda = held_ack;
                    else if (ph == 1) bus_scl = 1'b1;
                    else
                    begin
                        bus_scl = 1'b0;
                        fin     = 1'b1;
                    end
                end
                default:
                begin
                    if (ph == 0) bus_sda = 1'b1;
                    else if (ph == 1) bus_scl = 1'b1;
                    else if (ph == 2) ack_latch = w.sda_sample;
                    else
                    begin
                        bus_scl = 1'b0;
                        fin     = 1'b1;
                    end
                end
            endcase
            if (fin)
            begin
                run_cmd   = CMD_NONE;
                run_phase = '0;
            end
            else
                run_phase = run_phase + 5'd1;
        end
        r.scl_level = bus_scl;
        r.sda_level = bus_sda;
        r.busy_res  = busy;
        r.done_res  = fin;
        r.read_byte = byte_latch;
        r.ack_seen  = ack_latch;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        mismatches++;
        $display("%0t ns: mismatch on %s, got %h, expected %h", $time, what, got, want);
    endtask

    task automatic check_field(string what, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pin_results_q.size() == 0)
                report_mismatch("unexpected word", res_word.read_byte, 8'h00);
            else
            begin
                want = pin_results_q.pop_front();
                check_field("scl_level", 8'(res_word.scl_level), 8'(want.scl_level));
                check_field("sda_level", 8'(res_word.sda_level), 8'(want.sda_level));
                check_field("busy_res", 8'(res_word.busy_res), 8'(want.busy_res));
                check_field("done_res", 8'(res_word.done_res), 8'(want.done_res));
                check_field("read_byte", res_word.read_byte, want.read_byte);
                check_field("ack_seen", 8'(res_word.ack_seen), 8'(want.ack_seen));
            end
        end
    end

    // receiver back-pressure
    initial
    begin
        res_ready  <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                res_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_ready <= 1'b1;
                if ($urandom_range(0, 9) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic send_word(in_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_word  <= w;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cmd_ready);
        pin_results_q.push_back(step_bus(w));
        words_sent++;
    endtask

    // command word then the words (ticks, or random kinds when noisy) that carry it to completion
    task automatic run_command(logic [2:0] kind, logic [7:0] data, logic ack,
                               logic [7:0] line, bit noisy);
        int       len;
        in_word_t w;
        case (kind)
            KIND_START: len = 4;
            KIND_STOP:  len = 3;
            KIND_WRITE: len = 3 * BITS_PER_BYTE;
            KIND_READ:  len = 2 * BITS_PER_BYTE + 1;
            KIND_SACK:  len = 3;
            KIND_RACK:  len = 4;
            default:    len = 1;
        endcase
        for (int i = 0; i < len; i++)
        begin
            w = make_word(noisy ? 3'($urandom_range(0, 7)) : KIND_TICK, 8'($urandom),
                          1'($urandom), 1'($urandom));
            if (i == 0)
            begin
                w.kind       = kind;
                w.write_data = data;
                w.ack_level  = ack;
            end
            if (kind == KIND_READ && i >= 2 && i % 2 == 0)
                w.sda_sample = line[BITS_PER_BYTE - i / 2];
            if (kind == KIND_RACK && i == 2)
                w.sda_sample = line[0];
            send_word(w);
        end
    endtask

    task automatic test_idle_ticks();
        send_word(make_word(KIND_TICK, 8'h00, 1'b0, 1'b0));
        send_word(make_word(KIND_TICK, 8'hff, 1'b1, 1'b1));
        send_word(make_word(3'd7, 8'hff, 1'b1, 1'b0));
        send_word(make_word(3'd7, 8'h00, 1'b0, 1'b1));
    endtask

    task automatic test_each_command();
        run_command(KIND_START, 8'h00, 1'b0, 8'h00, 1'b0);
        run_command(KIND_WRITE, 8'hff, 1'b0, 8'h00, 1'b0);
        run_command(KIND_WRITE, 8'h00, 1'b1, 8'h00, 1'b0);
        run_command(KIND_RACK, 8'h00, 1'b0, 8'h00, 1'b0);
        run_command(KIND_READ, 8'h00, 1'b0, 8'ha5, 1'b0);
        run_command(KIND_SACK, 8'h00, 1'b0, 8'h00, 1'b0);
        run_command(KIND_READ, 8'h00, 1'b0, 8'h5a, 1'b0);
        run_command(KIND_SACK, 8'h00, 1'b1, 8'h00, 1'b0);
        run_command(KIND_RACK, 8'h00, 1'b0, 8'h01, 1'b0);
        run_command(KIND_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
    endtask

    task automatic test_busy_commands();
        run_command(KIND_START, 8'h00, 1'b1, 8'h00, 1'b1);
        run_command(KIND_WRITE, 8'h96, 1'b1, 8'h00, 1'b1);
        run_command(KIND_READ, 8'h00, 1'b1, 8'hc3, 1'b1);
        run_command(KIND_STOP, 8'h00, 1'b0, 8'h00, 1'b1);
    endtask

    task automatic test_random_traffic(int count);
        int last;
        int r;
        last = words_sent + count;
        while (words_sent < last)
        begin
            no_gaps = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 9);
            if (r < 7)
                run_command(3'($urandom_range(1, 6)), 8'($urandom), 1'($urandom),
                            8'($urandom), $urandom_range(0, 3) == 0);
            else if (r < 9)
                repeat ($urandom_range(1, 4))
                    send_word(make_word(KIND_TICK, 8'($urandom), 1'($urandom),
                                        1'($urandom)));
            else
                repeat ($urandom_range(1, 5))
                    send_word(make_word(3'($urandom), 8'($urandom), 1'($urandom),
                                        1'($urandom)));
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        int waited;
        rst_n      = 1'b0;
        cmd_valid  <= 1'b0;
        cmd_word   <= '0;
        mismatches = 0;
        words_sent = 0;
        no_gaps    = 1'b0;
        reset_bus();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_ticks();
        test_each_command();
        test_busy_commands();
        test_random_traffic(2000);

        cmd_valid <= 1'b0;
        waited = 0;
        while (pin_results_q.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pin_results_q.size() != 0)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            repeat (10) @(posedge clk);
            if (mismatches == 0)
                $display("SUCCESS");
            else
                $display("FAILURE");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
design/i2cbl_pkg.sv
design/i2cbl_front.sv
design/i2cbl_engine.sv
design/i2c_bit_level_master.sv
design/i2cbl_checker.sv
tb/tb_i2c_bit_level_master.sv
